### rtl/sida_pkg.sv
`default_nettype none

package sida_pkg;

   // Sizes of the data path and the default array depth.
   localparam int DEPTH_DEFAULT = 8;
   localparam int WORD_W        = 32;
   localparam int POS_W         = 3;
   // Wide enough to hold any cell index and the depth itself (up to 127).
   localparam int CELL_IDX_W    = 7;

   // Request codes.
   typedef enum logic [POS_W-1:0] {
      OP_INSERT  = 3'd0,
      OP_REPLACE = 3'd1,
      OP_DELETE  = 3'd2,
      OP_REVERSE = 3'd3,
      OP_SEARCH  = 3'd4,
      OP_READ    = 3'd5
   } op_type;

   // Command broadcast from the top level to every cell.
   typedef struct packed {
      logic                     en;
      op_type                   op;
      logic [POS_W-1:0]         pos;
      logic signed [WORD_W-1:0] value;
   } sida_ctrl_type;

endpackage

`default_nettype wire

### rtl/shift_insert_delete_array.sv
// Channel | Direction | Ports
// req     | in        | req_valid, req_stall, req_type, req_position, req_value
// rsp     | out       | rsp_valid, rsp_stall, rsp_found, rsp_found_index, rsp_read_value
//
// One word is accepted per cycle while req_stall is low; its result word passes through
// the compare stage register and then the output register before rsp_valid rises.
// Every cell of the row shifts, swaps or compares in the accept cycle, and the
// lowest-match encoder runs in the following cycle ahead of the output register.
// Reset is synchronous and clears all words to zero and empties both stages.
// A stalled result holds the output register; the request side stalls only when
// both stages are full and the result is stalled.
`default_nettype none

module shift_insert_delete_array #(
   parameter int DEPTH = sida_pkg::DEPTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [sida_pkg::POS_W-1:0]         req_type,
   input  wire logic [sida_pkg::POS_W-1:0]         req_position,
   input  wire logic signed [sida_pkg::WORD_W-1:0] req_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_found,
   output logic [sida_pkg::POS_W-1:0]              rsp_found_index,
   output logic signed [sida_pkg::WORD_W-1:0]      rsp_read_value
);
   import sida_pkg::*;

   localparam int READ_N = (DEPTH < 8) ? DEPTH : 8;

   sida_ctrl_type            ctrl;
   logic                     accept;
   logic signed [WORD_W-1:0] words [DEPTH];
   logic [DEPTH-1:0]         match;

   logic                     s1_valid_ff, s1_valid_in;
   logic [DEPTH-1:0]         s1_match_ff, s1_match_in;
   logic signed [WORD_W-1:0] s1_read_ff, s1_read_in;

   logic                     out_valid_ff, out_valid_in;
   logic                     out_found_ff, out_found_in;
   logic [POS_W-1:0]         out_index_ff, out_index_in;
   logic signed [WORD_W-1:0] out_read_ff, out_read_in;

   logic                     out_load;
   logic                     s1_free;
   logic                     pick_found;
   logic [POS_W-1:0]         pick_index;

   // Handshake between the request side, the compare stage and the output register.
   assign out_load  = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign s1_free   = !s1_valid_ff || out_load;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;

   // Command broadcast to the row of cells.
   assign ctrl.en    = accept;
   assign ctrl.op    = op_type'(req_type);
   assign ctrl.pos   = req_position;
   assign ctrl.value = req_value;

   // Row of cells, each linked to its neighbors (zero past either end) and to its mirror cell.
   for (genvar k = 0; k < DEPTH; k++) begin : g_row
      logic signed [WORD_W-1:0] left_w;
      logic signed [WORD_W-1:0] right_w;

      if (k == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_inner_l
         assign left_w = words[k-1];
      end

      if (k == DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_inner_r
         assign right_w = words[k+1];
      end

      sida_cell #(
         .DEPTH (DEPTH),
         .IDX   (k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_word   (left_w),
         .right_word  (right_w),
         .mirror_word (words[DEPTH-1-k]),
         .word        (words[k]),
         .match       (match[k])
      );
   end

   // Compare stage: capture the match vector for a search and the word for a read.
   always_comb begin
      s1_match_in = (ctrl.op == OP_SEARCH) ? match : '0;
      s1_read_in  = '0;
      if (ctrl.op == OP_READ) begin
         for (int k = 0; k < READ_N; k++) begin
            if (req_position == POS_W'(k)) begin
               s1_read_in = words[k];
            end
         end
      end
      s1_valid_in = accept || (s1_valid_ff && !out_load);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_match_ff <= s1_match_in;
         s1_read_ff  <= s1_read_in;
      end
   end

   sida_pick #(
      .DEPTH (DEPTH)
   ) u_pick (
      .match       (s1_match_ff),
      .found       (pick_found),
      .found_index (pick_index)
   );

   // Output register.
   always_comb begin
      out_found_in = pick_found;
      out_index_in = pick_index;
      out_read_in  = s1_read_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_found_ff <= out_found_in;
         out_index_ff <= out_index_in;
         out_read_ff  <= out_read_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_found       = out_found_ff;
   assign rsp_found_index = out_index_ff;
   assign rsp_read_value  = out_read_ff;

`ifndef SYNTH
   // The request side stalls only behind a stalled result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_stall && out_valid_ff && s1_valid_ff))
      else $error("request stalled without a stalled result");

   // A result that did not find anything reports index zero.
   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_found_index == '0))
      else $error("nonzero index without a match");

   // A search result never carries read data.
   a_search_no_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_read_value == '0))
      else $error("search result carries read data");

   // A replace at the bottom slot lands in the first cell.
   a_replace_first: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == OP_REPLACE && req_position == '0)
         |=> (words[0] == $past(req_value)))
      else $error("replace at the bottom slot lost");

   // Reset leaves the bottom word at zero.
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> (words[0] == '0))
      else $error("bottom word not cleared by reset");
`endif

endmodule

`default_nettype wire

### rtl/sida_cell.sv
`default_nettype none

module sida_cell #(
   parameter int DEPTH = 8,
   parameter int IDX   = 0
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire sida_pkg::sida_ctrl_type            ctrl,
   input  wire logic signed [sida_pkg::WORD_W-1:0] left_word,
   input  wire logic signed [sida_pkg::WORD_W-1:0] right_word,
   input  wire logic signed [sida_pkg::WORD_W-1:0] mirror_word,
   output logic signed [sida_pkg::WORD_W-1:0]      word,
   output logic                                    match
);
   import sida_pkg::*;

   localparam logic [CELL_IDX_W-1:0] MY_IDX   = CELL_IDX_W'(IDX);
   localparam logic [CELL_IDX_W-1:0] DEPTH_CI = CELL_IDX_W'(DEPTH);

   logic signed [WORD_W-1:0] word_ff;
   logic signed [WORD_W-1:0] word_in;
   logic [CELL_IDX_W-1:0]    pos_ext;
   logic                     in_range;
   logic                     at_pos;
   logic                     above_pos;

   // Where this cell sits relative to the requested position.
   assign pos_ext   = CELL_IDX_W'(ctrl.pos);
   assign in_range  = pos_ext < DEPTH_CI;
   assign at_pos    = pos_ext == MY_IDX;
   assign above_pos = MY_IDX > pos_ext;

   // Pick the next word: hold, take a neighbor, take the mirror or load the request word.
   always_comb begin
      word_in = word_ff;
      if (ctrl.en) begin
         case (ctrl.op)
            OP_INSERT: begin
               if (in_range && above_pos) begin
                  word_in = left_word;
               end else if (in_range && at_pos) begin
                  word_in = ctrl.value;
               end
            end
            OP_REPLACE: begin
               if (in_range && at_pos) begin
                  word_in = ctrl.value;
               end
            end
            OP_DELETE: begin
               if (in_range && (above_pos || at_pos)) begin
                  word_in = right_word;
               end
            end
            OP_REVERSE: begin
               word_in = mirror_word;
            end
            default: begin
               word_in = word_ff;
            end
         endcase
      end
   end

   // The stored word clears to zero at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else begin
         word_ff <= word_in;
      end
   end

   assign word  = word_ff;
   assign match = word_ff == ctrl.value;

endmodule

`default_nettype wire

### rtl/sida_pick.sv
`default_nettype none

module sida_pick #(
   parameter int DEPTH = 8
) (
   input  wire logic [DEPTH-1:0]                 match,
   output logic                                  found,
   output logic [sida_pkg::POS_W-1:0]            found_index
);
   import sida_pkg::*;

   logic [DEPTH-1:0] lowest;

   // Isolate the lowest set match bit.
   assign lowest = match & (~match + DEPTH'(1));

   // Encode the isolated bit; the index is kept to the width of the result field.
   always_comb begin
      found       = |match;
      found_index = '0;
      for (int k = 0; k < DEPTH; k++) begin
         if (lowest[k]) begin
            found_index = found_index | POS_W'(k);
         end
      end
   end

endmodule

`default_nettype wire
